// ----- sv/tkd_pkg.sv -----
// Shared types, constants and codes of the transition key dedup table.
package tkd_pkg;

    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int DEF_MAX_ROWS      = 512;

    localparam int SRC_W   = 8;
    localparam int ADDR_W  = 64;
    localparam int KEY_W   = SRC_W + 2 * ADDR_W;
    localparam int EPOCH_W = 8;

    localparam logic [63:0] MIX_ADD = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_K1  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_K2  = 64'h94d0_49bb_1331_11eb;
    localparam int          MIX_S0  = 30;
    localparam int          MIX_S1  = 27;
    localparam int          MIX_S2  = 31;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;
    localparam logic [1:0] ST_CLEARED   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] destination;
        logic [ADDR_W-1:0] exit_addr;
        logic [SRC_W-1:0]  source;
    } key_t;

endpackage

// ----- sv/tkd_hash.sv -----
// Sequential key mixer with one shared 32x32 multiplier and slot reduction.
module tkd_hash #(
    parameter int TABLE_ENTRIES = tkd_pkg::DEF_TABLE_ENTRIES,
    parameter int SLOT_W        = $clog2(TABLE_ENTRIES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tkd_pkg::key_t     key,
    output logic              done,
    output logic [SLOT_W-1:0] slot
);
    import tkd_pkg::*;

    localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int RW      = SLOT_W + 1;

    localparam logic [3:0] H_IDLE = 4'd0;
    localparam logic [3:0] H_M1A  = 4'd1;
    localparam logic [3:0] H_M1B  = 4'd2;
    localparam logic [3:0] H_M1C  = 4'd3;
    localparam logic [3:0] H_X1   = 4'd4;
    localparam logic [3:0] H_M2A  = 4'd5;
    localparam logic [3:0] H_M2B  = 4'd6;
    localparam logic [3:0] H_M2C  = 4'd7;
    localparam logic [3:0] H_X2   = 4'd8;
    localparam logic [3:0] H_REM  = 4'd9;
    localparam logic [3:0] H_DONE = 4'd10;

    logic [3:0]        phase_reg, phase_next;
    logic [63:0]       v_reg, v_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       h_reg, h_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [63:0] mix0;
    logic [63:0] k_sel;
    logic [31:0] a_op, b_op;
    logic [63:0] prod;
    logic [63:0] h_fin;
    logic [RW-1:0] r;

    assign mix0  = key.exit_addr ^ (key.destination + MIX_ADD)
                 ^ {{(64 - SRC_W){1'b0}}, key.source};
    assign k_sel = (phase_reg <= H_X1) ? MIX_K1 : MIX_K2;
    assign a_op  = (phase_reg == H_M1C || phase_reg == H_M2C) ? v_reg[63:32] : v_reg[31:0];
    assign b_op  = (phase_reg == H_M1B || phase_reg == H_M2B) ? k_sel[63:32] : k_sel[31:0];
    assign prod  = 64'(a_op) * 64'(b_op);
    assign h_fin = acc_reg ^ (acc_reg >> MIX_S2);

    always_comb
    begin
        phase_next = phase_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        h_next     = h_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        r          = rem_reg;
        unique case (phase_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    v_next     = mix0 ^ (mix0 >> MIX_S0);
                    phase_next = H_M1A;
                end
            end
            H_M1A, H_M2A:
            begin
                acc_next   = prod;
                phase_next = phase_reg + 4'd1;
            end
            H_M1B, H_M1C, H_M2B, H_M2C:
            begin
                acc_next   = acc_reg + {prod[31:0], 32'b0};
                phase_next = phase_reg + 4'd1;
            end
            H_X1:
            begin
                v_next     = acc_reg ^ (acc_reg >> MIX_S1);
                phase_next = H_M2A;
            end
            H_X2:
            begin
                if (IS_POW2)
                begin
                    slot_next  = h_fin[SLOT_W-1:0];
                    phase_next = H_DONE;
                end
                else
                begin
                    h_next     = h_fin;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = H_REM;
                end
            end
            H_REM:
            begin
                // eight restoring remainder steps, msb first
                for (int i = 0; i < 8; i++)
                begin
                    r = {r[RW-2:0], h_reg[63 - i]};
                    if (r >= RW'(TABLE_ENTRIES))
                        r = r - RW'(TABLE_ENTRIES);
                end
                rem_next = r;
                h_next   = {h_reg[55:0], 8'b0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    slot_next  = r[SLOT_W-1:0];
                    phase_next = H_DONE;
                end
            end
            H_DONE:
            begin
                phase_next = H_IDLE;
            end
            default:
            begin
                phase_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= H_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        acc_reg  <= acc_next;
        h_reg    <= h_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        slot_reg <= slot_next;
    end

    assign done = (phase_reg == H_DONE);
    assign slot = slot_reg;

endmodule

// ----- sv/tkd_front.sv -----
// Front end: accepts input beats, hashes inserts and pushes work into the queue.
module tkd_front #(
    parameter int TABLE_ENTRIES = tkd_pkg::DEF_TABLE_ENTRIES,
    parameter int SLOT_W        = $clog2(TABLE_ENTRIES),
    parameter int QW            = 1 + tkd_pkg::KEY_W + SLOT_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [tkd_pkg::KEY_W-1:0]  s_axis_tdata,
    input  logic [0:0]                 s_axis_tuser,
    output logic                       push,
    output logic [QW-1:0]              push_data,
    input  logic                       full
);
    import tkd_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              op_reg;
    key_t              key_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              accept;
    logic              hash_start;
    logic              hash_done;
    logic [SLOT_W-1:0] hash_slot;

    assign s_axis_tready = (state_reg == F_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hash_start    = accept && (s_axis_tuser[0] == OP_INSERT);

    tkd_hash #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SLOT_W        (SLOT_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (key_t'(s_axis_tdata)),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = (s_axis_tuser[0] == OP_CLEAR) ? F_PUSH : F_HASH;
            end
            F_HASH:
            begin
                if (hash_done)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_axis_tuser[0];
            key_reg  <= key_t'(s_axis_tdata);
            slot_reg <= '0;
        end
        else if (state_reg == F_HASH && hash_done)
        begin
            slot_reg <= hash_slot;
        end
    end

    assign push      = (state_reg == F_PUSH) && !full;
    assign push_data = {op_reg, key_reg, slot_reg};

endmodule

// ----- sv/tkd_queue.sv -----
// Two-entry work queue between the front end and the probe engine.
module tkd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/tkd_back.sv -----
// Probe engine: epoch-tagged key table, linear probe, distinct count, result register.
module tkd_back #(
    parameter int TABLE_ENTRIES = tkd_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_ROWS      = tkd_pkg::DEF_MAX_ROWS,
    parameter int SLOT_W        = $clog2(TABLE_ENTRIES),
    parameter int QW            = 1 + tkd_pkg::KEY_W + SLOT_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  logic [QW-1:0] q_data,
    output logic          pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata
);
    import tkd_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int MW    = EPOCH_W + KEY_W;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
    localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] B_SWEEP = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_PROBE = 2'd2;

    logic [MW-1:0] mem [TABLE_ENTRIES];
    logic [MW-1:0] rd_data_reg;

    logic [1:0]         state_reg, state_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  sweep_reg, sweep_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  tries_reg, tries_next;
    key_t               key_reg, key_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;

    logic               q_op;
    key_t               q_key;
    logic [SLOT_W-1:0]  q_slot;
    logic               out_free;
    logic               we;
    logic [SLOT_W-1:0]  wa;
    logic [MW-1:0]      wd;
    logic [SLOT_W-1:0]  ra;
    logic [EPOCH_W-1:0] rd_tag;
    key_t               rd_key;
    logic [SLOT_W-1:0]  slot_inc;

    assign q_op     = q_data[QW-1];
    assign q_key    = key_t'(q_data[SLOT_W +: KEY_W]);
    assign q_slot   = q_data[SLOT_W-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rd_tag   = rd_data_reg[MW-1 -: EPOCH_W];
    assign rd_key   = key_t'(rd_data_reg[KEY_W-1:0]);
    assign slot_inc = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        count_next     = count_reg;
        sweep_next     = sweep_reg;
        slot_next      = slot_reg;
        tries_next     = tries_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        status_next    = status_reg;
        pop            = 1'b0;
        we             = 1'b0;
        wa             = slot_reg;
        wd             = {epoch_reg, key_reg};
        ra             = slot_inc;
        unique case (state_reg)
            B_SWEEP:
            begin
                we         = 1'b1;
                wa         = sweep_reg;
                wd         = '0;
                sweep_next = sweep_reg + SLOT_W'(1);
                if (sweep_reg == SLOT_LAST)
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                ra = q_slot;
                if (q_valid && out_free)
                begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    key_next       = q_key;
                    slot_next      = q_slot;
                    tries_next     = '0;
                    if (q_op == OP_CLEAR)
                    begin
                        status_next = ST_CLEARED;
                        count_next  = '0;
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            epoch_next = EPOCH_FIRST;
                            sweep_next = '0;
                            state_next = B_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                    else if (count_reg >= CNT_W'(MAX_ROWS))
                    begin
                        status_next = ST_LIMIT;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = B_PROBE;
                    end
                end
            end
            B_PROBE:
            begin
                if (rd_tag != epoch_reg)
                begin
                    we             = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    status_next    = ST_INSERTED;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
                else if (rd_key == key_reg)
                begin
                    status_next    = ST_DUPLICATE;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
                else if (tries_reg == SLOT_LAST)
                begin
                    status_next    = ST_LIMIT;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
                else
                begin
                    slot_next  = slot_inc;
                    tries_next = tries_reg + SLOT_W'(1);
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            epoch_reg     <= EPOCH_FIRST;
            count_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        tries_reg  <= tries_next;
        key_reg    <= key_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[ra];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, status_reg};

endmodule

// ----- sv/transition_key_dedup_table.sv -----
// Top level of the transition key dedup table: front end, work queue, probe engine.
//
// Per-window duplicate filter for (source, from, destination) keys. Each insert
// beat returns one status beat: inserted, duplicate, row limit reached; a close
// window beat returns window cleared. The front end takes one beat at a time:
// an insert is hashed by the splitmix mixer, which runs six 32x32 partial
// products through one shared multiplier, followed by a slot remainder when
// TABLE_ENTRIES is not a power of two; a close window beat skips the hash. The
// probe engine runs behind a two-entry queue; it answers a close window or a row
// limit without probing, and for an insert it reads one table slot per cycle
// from the key memory. Entries are epoch tagged, so a close window clears by
// advancing the epoch; after reset and after every 255th close window a clearing
// pass rewrites the tags of all TABLE_ENTRIES entries, while input beats keep
// queuing up to the queue depth.
module transition_key_dedup_table #(
    parameter int TABLE_ENTRIES = tkd_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_ROWS      = tkd_pkg::DEF_MAX_ROWS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [tkd_pkg::KEY_W-1:0] s_axis_tdata,  // source, exit_addr, destination
    input  logic [0:0]                s_axis_tuser,  // op
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata   // status, zero fill
);
    import tkd_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int QW     = 1 + KEY_W + SLOT_W;

    logic          push;
    logic [QW-1:0] push_data;
    logic          full;
    logic          pop;
    logic          q_valid;
    logic [QW-1:0] q_data;

    tkd_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SLOT_W        (SLOT_W),
        .QW            (QW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    tkd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    tkd_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_ROWS      (MAX_ROWS),
        .SLOT_W        (SLOT_W),
        .QW            (QW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- bench/transition_key_dedup_table_test.sv -----
// Self-checking bench for the transition key dedup table: scoreboard predictor and stream drivers.
module transition_key_dedup_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tkd_pkg::*;

    localparam int TBL   = DEF_TABLE_ENTRIES;
    localparam int ROWS  = DEF_MAX_ROWS;
    localparam int LIMIT = 600000;

    class dedup_scoreboard;
        bit          valid [TBL];
        key_t        stored [TBL];
        int unsigned distinct;
        logic [1:0]  status_expected [$];
        int          errors;
        int          seen [4];

        function logic [63:0] key_hash(key_t k);
            logic [63:0] v;
            v = k.exit_addr ^ (k.destination + MIX_ADD) ^ {56'd0, k.source};
            v ^= v >> MIX_S0;
            v = v * MIX_K1;
            v ^= v >> MIX_S1;
            v = v * MIX_K2;
            return v ^ (v >> MIX_S2);
        endfunction

        function logic [1:0] insert_status(key_t k);
            int unsigned slot;
            if (distinct >= ROWS)
                return ST_LIMIT;
            slot = 32'(key_hash(k) % 64'(TBL));
            for (int i = 0; i < TBL; i++)
            begin
                if (!valid[slot])
                begin
                    valid[slot]  = 1'b1;
                    stored[slot] = k;
                    distinct++;
                    return ST_INSERTED;
                end
                if (stored[slot] == k)
                    return ST_DUPLICATE;
                slot = (slot + 1) % TBL;
            end
            return ST_LIMIT;
        endfunction

        function void note_beat(logic op, key_t k);
            if (op == OP_CLEAR)
            begin
                foreach (valid[i])
                    valid[i] = 1'b0;
                distinct = 0;
                status_expected.push_back(ST_CLEARED);
            end
            else
                status_expected.push_back(insert_status(k));
        endfunction

        function void check_status(logic [1:0] got);
            logic [1:0] want;
            seen[got]++;
            if (status_expected.size() == 0)
            begin
                $display("%0t: unexpected status beat, expected none actual %0d", $time, got);
                errors++;
                return;
            end
            want = status_expected.pop_front();
            if (got !== want)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [KEY_W-1:0]     s_axis_tdata;   // source, exit_addr, destination
    logic [0:0]           s_axis_tuser;   // op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // status, zero fill

    dedup_scoreboard sb;
    bit              sender_burst;
    int unsigned     cycles;

    transition_key_dedup_table #(
        .TABLE_ENTRIES(TBL),
        .MAX_ROWS(ROWS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata[1:0]);

    // receiver: bursts of full rate, random stalls, occasional long stalls
    initial
    begin
        int r;
        int len;
        m_axis_tready = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                len = $urandom_range(1, 30);
                repeat (len) @(negedge clk) m_axis_tready <= 1'b1;
            end
            else if (r < 90)
            begin
                len = $urandom_range(1, 20);
                repeat (len) @(negedge clk) m_axis_tready <= 1'($urandom_range(0, 1));
            end
            else
            begin
                len = $urandom_range(5, 40);
                repeat (len) @(negedge clk) m_axis_tready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (sender_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic key_t random_key();
        key_t k;
        k.source      = 8'($urandom_range(0, 255));
        k.exit_addr   = {$urandom, $urandom};
        k.destination = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0)
            k.exit_addr = 64'($urandom_range(0, 15));
        if ($urandom_range(0, 7) == 0)
            k.destination = 64'($urandom_range(0, 15));
        return k;
    endfunction

    function automatic key_t key_at_slot(int unsigned slot);
        key_t k;
        do
            k = random_key();
        while (sb.key_hash(k) % 64'(TBL) != slot);
        return k;
    endfunction

    task automatic send_beat(input logic op, input key_t k);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= k;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_beat(op, k);
        gap = pick_gap();
        repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (sb.status_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_window(input int n, input int dup_pct, input int mut_pct,
                              input int clr_pct);
        key_t pool [$];
        key_t k;
        int   r;
        int   b;
        sender_burst = ($urandom_range(0, 3) == 0);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < clr_pct)
            begin
                send_beat(OP_CLEAR, random_key());
                pool.delete();
            end
            else
            begin
                if (pool.size() != 0 && r < clr_pct + dup_pct)
                    k = pool[$urandom_range(0, pool.size() - 1)];
                else if (pool.size() != 0 && r < clr_pct + dup_pct + mut_pct)
                begin
                    // near miss: one bit of one field differs from a stored key
                    k = pool[$urandom_range(0, pool.size() - 1)];
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            b = $urandom_range(0, 7);
                            k.source[b] = ~k.source[b];
                        end
                        1: k.exit_addr ^= 64'd1 << $urandom_range(0, 63);
                        default: k.destination ^= 64'd1 << $urandom_range(0, 63);
                    endcase
                end
                else
                    k = random_key();
                send_beat(OP_INSERT, k);
                pool.push_back(k);
            end
        end
    endtask

    initial
    begin
        key_t zero_key;
        key_t ones_key;
        key_t k;
        key_t wrap_a;
        key_t wrap_b;
        key_t wrap_c;

        sb = new;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INSERT;
        sender_burst  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        zero_key = '0;
        ones_key = '1;
        send_beat(OP_CLEAR, zero_key);
        send_beat(OP_INSERT, zero_key);
        send_beat(OP_INSERT, zero_key);
        send_beat(OP_INSERT, ones_key);
        send_beat(OP_INSERT, ones_key);
        k = '0;
        k.source = '1;
        send_beat(OP_INSERT, k);
        k = '0;
        k.exit_addr = '1;
        send_beat(OP_INSERT, k);
        k = '0;
        k.destination = '1;
        send_beat(OP_INSERT, k);
        send_beat(OP_INSERT, zero_key);
        send_beat(OP_CLEAR, ones_key);
        send_beat(OP_INSERT, zero_key);
        send_beat(OP_INSERT, {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 8'haa});
        send_beat(OP_INSERT, {64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 8'h55});
        // collision chain across the table end
        wrap_a = key_at_slot(TBL - 1);
        wrap_b = key_at_slot(TBL - 1);
        wrap_c = key_at_slot(0);
        send_beat(OP_INSERT, wrap_a);
        send_beat(OP_INSERT, wrap_b);
        send_beat(OP_INSERT, wrap_c);
        send_beat(OP_INSERT, wrap_b);
        send_beat(OP_INSERT, wrap_c);
        send_beat(OP_INSERT, wrap_a);
        send_beat(OP_CLEAR, random_key());
        drain_results();

        repeat (3)
        begin
            run_window($urandom_range(5, 20), 30, 15, 2);
            send_beat(OP_CLEAR, random_key());
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end

        // fill one window past the row limit, then hit stored keys while full
        drain_results();
        run_window(540, 3, 10, 0);
        send_beat(OP_CLEAR, random_key());

        run_window($urandom_range(5, 20), 30, 15, 2);
        send_beat(OP_CLEAR, random_key());

        drain_results();
        repeat (100) @(posedge clk);

        if (sb.status_expected.size() != 0)
        begin
            $display("%0t: %0d status beats never arrived", $time, sb.status_expected.size());
            sb.errors++;
        end
        $display("Statuses seen: %0d inserted, %0d duplicate, %0d row limit, %0d cleared",
                 sb.seen[ST_INSERTED], sb.seen[ST_DUPLICATE], sb.seen[ST_LIMIT],
                 sb.seen[ST_CLEARED]);
        $display("Mismatches: %0d over %0d cycles", sb.errors, cycles);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
